// ----- sv/hrc_pkg.sv -----
// shared types, constants and lookup functions for the http request classifier
package hrc_pkg;

    localparam int unsigned BUFFER_BYTES_DEFAULT = 2048;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QUERY = 8'h3f;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    localparam logic [7:0] GET_LEN   = 8'd3;
    localparam logic [7:0] HEAD_LEN  = 8'd4;
    localparam logic [7:0] ROOT_LEN  = 8'd1;
    localparam logic [7:0] INDEX_LEN = 8'd11;
    localparam logic [7:0] POS_MAX   = 8'd255;

    localparam logic [15:0] NOT_FOUND_LEN = 16'd63;

    // verdict flag bits
    localparam logic [2:0] VF_BAD  = 3'b001;
    localparam logic [2:0] VF_GET  = 3'b010;
    localparam logic [2:0] VF_HEAD = 3'b100;

    typedef enum logic [1:0] {
        PH_METHOD = 2'd0,
        PH_TARGET = 2'd1,
        PH_QUERY  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOTIMPL  = 3'd3,
        ST_NOREQ    = 3'd4
    } status_t;

    // crlf crlf search progress
    typedef enum logic [1:0] {
        TP_NONE   = 2'd0,
        TP_CR     = 2'd1,
        TP_CRLF   = 2'd2,
        TP_CRLFCR = 2'd3
    } term_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] pos;
        logic [1:0] mmatch;   // bit0 GET, bit1 HEAD still possible
        logic [1:0] tmatch;   // bit0 "/", bit1 "/index.html" still possible
        logic       tempty;
        term_t      term;
        logic [2:0] flags;
    } parse_state_t;

    typedef struct packed {
        status_t     status;
        logic        send_body;
        logic [15:0] body_length;
    } result_t;

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h47; // G
            2'd1:    ch = 8'h45; // E
            2'd2:    ch = 8'h54; // T
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] head_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0: ch = 8'h48; // H
            2'd1: ch = 8'h45; // E
            2'd2: ch = 8'h41; // A
            2'd3: ch = 8'h44; // D
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] index_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h2f; // /
            4'd1:    ch = 8'h69; // i
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h64; // d
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h78; // x
            4'd6:    ch = 8'h2e; // .
            4'd7:    ch = 8'h68; // h
            4'd8:    ch = 8'h74; // t
            4'd9:    ch = 8'h6d; // m
            4'd10:   ch = 8'h6c; // l
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_delim(input logic [7:0] ch);
        return (ch == CH_NUL) || (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_LF);
    endfunction

    // a target prefix only matches if its length is exact
    function automatic logic [1:0] close_prefix(input logic [1:0] tm, input logic [7:0] pos);
        logic [1:0] r;
        r = tm;
        if (pos != ROOT_LEN) r[0] = 1'b0;
        if (pos != INDEX_LEN) r[1] = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] pos);
        return (pos == POS_MAX) ? pos : pos + 8'd1;
    endfunction

endpackage

// ----- sv/hrc_verdict.sv -----
// verdict logic: maps the final parse state to status and body fields
module hrc_verdict import hrc_pkg::*; (
    input  parse_state_t st,
    input  logic [15:0]  page_length,
    output result_t      res
);

    logic [2:0] flags;
    logic [1:0] tmatch;

    always_comb begin
        flags  = st.flags;
        tmatch = st.tmatch;
        if (st.phase == PH_METHOD) flags = VF_BAD;
        if (st.phase == PH_TARGET) tmatch = close_prefix(st.tmatch, st.pos);
        if (st.phase != PH_METHOD && st.tempty) flags = flags | VF_BAD;

        res.status      = ST_OK;
        res.send_body   = 1'b0;
        res.body_length = 16'd0;
        priority if ((flags & VF_BAD) != 3'd0) begin
            res.status = ST_BAD;
        end else if ((flags & (VF_GET | VF_HEAD)) == 3'd0) begin
            res.status = ST_NOTIMPL;
        end else if (tmatch != 2'd0) begin
            res.status      = ST_OK;
            res.body_length = page_length;
            res.send_body   = (flags & VF_GET) != 3'd0;
        end else begin
            res.status      = ST_NOTFOUND;
            res.body_length = NOT_FOUND_LEN;
            res.send_body   = (flags & VF_GET) != 3'd0;
        end
    end

endmodule

// ----- sv/hrc_parser.sv -----
// per-connection parse state, byte step logic and terminator search
module hrc_parser import hrc_pkg::*; #(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  byte_value,
    input  logic        connection_lost,
    input  logic [15:0] page_length,
    output logic        res_valid,
    output result_t     res
);

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_BYTES - 1);

    localparam parse_state_t ST_REARM = '{
        phase:  PH_METHOD,
        pos:    8'd0,
        mmatch: 2'b11,
        tmatch: 2'b11,
        tempty: 1'b1,
        term:   TP_NONE,
        flags:  3'd0
    };

    parse_state_t     st_reg, st_next, st_parsed;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic             term_hit;
    logic             delim;
    result_t          verdict_res;

    hrc_verdict u_verdict (
        .st          (st_parsed),
        .page_length (page_length),
        .res         (verdict_res)
    );

    always_comb begin
        st_parsed = st_reg;
        delim     = is_delim(byte_value);
        term_hit  = 1'b0;

        unique case (st_reg.phase)
            PH_METHOD: begin
                if (delim) begin
                    if (byte_value != CH_SPACE) begin
                        st_parsed.flags = VF_BAD;
                        st_parsed.phase = PH_DONE;
                    end else begin
                        if (st_reg.mmatch[0] && st_reg.pos == GET_LEN)
                            st_parsed.flags = st_parsed.flags | VF_GET;
                        if (st_reg.mmatch[1] && st_reg.pos == HEAD_LEN)
                            st_parsed.flags = st_parsed.flags | VF_HEAD;
                        st_parsed.phase = PH_TARGET;
                        st_parsed.pos   = 8'd0;
                    end
                end else begin
                    if (st_reg.pos >= GET_LEN || get_char(st_reg.pos[1:0]) != byte_value)
                        st_parsed.mmatch[0] = 1'b0;
                    if (st_reg.pos >= HEAD_LEN || head_char(st_reg.pos[1:0]) != byte_value)
                        st_parsed.mmatch[1] = 1'b0;
                    st_parsed.pos = bump(st_reg.pos);
                end
            end
            PH_TARGET: begin
                if (delim) begin
                    st_parsed.tmatch = close_prefix(st_reg.tmatch, st_reg.pos);
                    st_parsed.phase  = PH_DONE;
                end else begin
                    st_parsed.tempty = 1'b0;
                    if (byte_value == CH_QUERY) begin
                        st_parsed.tmatch = close_prefix(st_reg.tmatch, st_reg.pos);
                        st_parsed.phase  = PH_QUERY;
                    end else begin
                        if (st_reg.pos >= ROOT_LEN || byte_value != CH_SLASH)
                            st_parsed.tmatch[0] = 1'b0;
                        if (st_reg.pos >= INDEX_LEN
                            || index_char(st_reg.pos[3:0]) != byte_value)
                            st_parsed.tmatch[1] = 1'b0;
                        st_parsed.pos = bump(st_reg.pos);
                    end
                end
            end
            PH_QUERY: begin
                if (delim) st_parsed.phase = PH_DONE;
            end
            PH_DONE: begin
            end
        endcase

        // crlf crlf search runs on every byte
        priority if (byte_value == CH_CR) begin
            st_parsed.term = (st_reg.term == TP_CRLF) ? TP_CRLFCR : TP_CR;
        end else if (byte_value == CH_LF) begin
            priority if (st_reg.term == TP_CR) begin
                st_parsed.term = TP_CRLF;
            end else if (st_reg.term == TP_CRLFCR) begin
                st_parsed.term = TP_NONE;
                term_hit       = 1'b1;
            end else begin
                st_parsed.term = TP_NONE;
            end
        end else begin
            st_parsed.term = TP_NONE;
        end

        cnt_inc = cnt_reg + CNT_W'(1);

        res       = verdict_res;
        res_valid = 1'b0;
        st_next   = st_parsed;
        cnt_next  = cnt_inc;
        if (connection_lost) begin
            res_valid       = 1'b1;
            res.status      = ST_NOREQ;
            res.send_body   = 1'b0;
            res.body_length = 16'd0;
            st_next         = ST_REARM;
            cnt_next        = '0;
        end else if (term_hit || cnt_inc == CNT_LAST) begin
            res_valid = 1'b1;
            st_next   = ST_REARM;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_REARM;
            cnt_reg <= '0;
        end else if (step) begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/http_request_classifier_top.sv -----
// top level of the http request classifier: input register, parser, result register
//
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_byte_value[7:0], s_connection_lost
// m_        out  m_valid/m_ready    m_status[2:0], m_send_body, m_body_length[15:0]
// cfg_      in   cfg_valid/cfg_ready cfg_data[15:0] (page_length)
//
// one byte per cycle sustained while no verdict waits on a stalled m_: a beat is held in the input register, is
// parsed in one pass and its verdict, if any, lands in the result register
// from s_ accept to m_valid a beat passes the input register, then the result register
// aresetn is synchronous, active low; it clears page_length and re-arms the parser
// a stall on m_ only holds the input register while a verdict is still waiting
// cfg_ready is always high
module http_request_classifier_top import hrc_pkg::*; #(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_connection_lost,
    // verdict stream
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_send_body,
    output logic [15:0] m_body_length,
    // page length register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_lost_reg;

    // result register
    logic        out_valid_reg;
    result_t     out_res_reg;

    logic [15:0] page_length_reg;

    logic        fire;       // parser consumes the held beat
    logic        res_valid;
    result_t     res;

    // the held beat moves on when the result slot is free or being drained
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_value;
            in_lost_reg <= s_connection_lost;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_length_reg <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            page_length_reg <= cfg_data;
        end
    end

    hrc_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (fire),
        .byte_value      (in_byte_reg),
        .connection_lost (in_lost_reg),
        .page_length     (page_length_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // a beat with no verdict still frees the slot if it was being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_res_reg.status;
    assign m_send_body   = out_res_reg.send_body;
    assign m_body_length = out_res_reg.body_length;

    // lost connection always yields a no-request verdict next cycle
    a_lost_gives_noreq: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_lost_reg |=> m_valid && m_status == ST_NOREQ)
        else $error("lost connection did not give no-request verdict");

    // only 200 and 404 carry a body length or body
    a_no_body_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK && m_status != ST_NOTFOUND
        |-> !m_send_body && m_body_length == 16'd0)
        else $error("error verdict carries a body");

    a_notfound_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NOTFOUND |-> m_body_length == NOT_FOUND_LEN)
        else $error("404 verdict with wrong body length");

    // a beat is never consumed while an untaken verdict waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !fire)
        else $error("parser stepped over a pending verdict");

endmodule

// ----- test/tb_http_request_classifier_top.sv -----
`timescale 1ns / 1ps
// testbench for the http request classifier: directed and random request streams, scoreboard check
module tb_http_request_classifier_top;
    import hrc_pkg::*;

    localparam int unsigned BUF_BYTES    = BUFFER_BYTES_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PCT     = 11;
    localparam int unsigned DRAIN_CYCLES = 8;

    // words the parser looks for, right aligned
    localparam logic [87:0] GET_TEXT   = "GET";
    localparam logic [87:0] HEAD_TEXT  = "HEAD";
    localparam logic [87:0] INDEX_TEXT = "/index.html";

    // progress through the blank line that closes the headers
    localparam logic [2:0] SEEN_NONE   = 3'd0;
    localparam logic [2:0] SEEN_CR     = 3'd1;
    localparam logic [2:0] SEEN_CRLF   = 3'd2;
    localparam logic [2:0] SEEN_CRLFCR = 3'd3;
    localparam logic [2:0] SEEN_END    = 3'd4;

    // predicts one verdict per request from the accepted beats and checks the m_ side
    class verdict_predictor;
        logic [15:0] page_bytes;
        phase_t      phase;
        logic [7:0]  pos;
        logic [1:0]  method_ok;   // bit0 GET, bit1 HEAD still possible
        logic [1:0]  target_ok;   // bit0 "/", bit1 "/index.html" still possible
        logic        no_target;
        logic [2:0]  crlf_seen;
        logic [11:0] held;
        logic [2:0]  flags;
        result_t     expected_verdicts[$];
        int unsigned mismatches;

        function new();
            page_bytes = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_METHOD;
            pos       = '0;
            method_ok = 2'b11;
            target_ok = 2'b11;
            no_target = 1'b1;
            crlf_seen = SEEN_NONE;
            held      = '0;
            flags     = '0;
        endfunction

        function logic [7:0] letter_at(logic [87:0] w, int len, int k);
            return w[8*(len-1-k) +: 8];
        endfunction

        function logic breaks_token(logic [7:0] c);
            return c == CH_NUL || c == CH_SPACE || c == CH_CR || c == CH_LF;
        endfunction

        // a target only matches when its length is exact
        function void seal_target();
            if (pos != ROOT_LEN) target_ok[0] = 1'b0;
            if (pos != INDEX_LEN) target_ok[1] = 1'b0;
        endfunction

        function void advance();
            if (pos != POS_MAX) pos = pos + 8'd1;
        endfunction

        function void parse(logic [7:0] c);
            case (phase)
                PH_METHOD: begin
                    if (breaks_token(c)) begin
                        if (c != CH_SPACE) begin
                            flags = VF_BAD;
                            phase = PH_DONE;
                        end else begin
                            if (method_ok[0] && pos == GET_LEN) flags = flags | VF_GET;
                            if (method_ok[1] && pos == HEAD_LEN) flags = flags | VF_HEAD;
                            phase = PH_TARGET;
                            pos   = '0;
                        end
                    end else begin
                        if (pos >= GET_LEN || letter_at(GET_TEXT, 3, pos) != c)
                            method_ok[0] = 1'b0;
                        if (pos >= HEAD_LEN || letter_at(HEAD_TEXT, 4, pos) != c)
                            method_ok[1] = 1'b0;
                        advance();
                    end
                end
                PH_TARGET: begin
                    if (breaks_token(c)) begin
                        seal_target();
                        phase = PH_DONE;
                    end else begin
                        no_target = 1'b0;
                        if (c == CH_QUERY) begin
                            seal_target();
                            phase = PH_QUERY;
                        end else begin
                            if (pos != 0 || c != CH_SLASH) target_ok[0] = 1'b0;
                            if (pos >= INDEX_LEN || letter_at(INDEX_TEXT, 11, pos) != c)
                                target_ok[1] = 1'b0;
                            advance();
                        end
                    end
                end
                PH_QUERY: begin
                    if (breaks_token(c)) phase = PH_DONE;
                end
                default: ;
            endcase
        endfunction

        function void scan(logic [7:0] c);
            if (c == CH_CR) begin
                crlf_seen = (crlf_seen == SEEN_CRLF) ? SEEN_CRLFCR : SEEN_CR;
            end else if (c == CH_LF) begin
                if (crlf_seen == SEEN_CR) crlf_seen = SEEN_CRLF;
                else if (crlf_seen == SEEN_CRLFCR) crlf_seen = SEEN_END;
                else crlf_seen = SEEN_NONE;
            end else begin
                crlf_seen = SEEN_NONE;
            end
        endfunction

        function void conclude();
            result_t v;
            if (phase == PH_METHOD) flags = VF_BAD;
            if (phase == PH_TARGET) seal_target();
            if (phase != PH_METHOD && no_target) flags = flags | VF_BAD;
            v.send_body   = 1'b0;
            v.body_length = '0;
            if ((flags & VF_BAD) != 0) begin
                v.status = ST_BAD;
            end else if ((flags & (VF_GET | VF_HEAD)) == 0) begin
                v.status = ST_NOTIMPL;
            end else begin
                v.status      = (target_ok != 0) ? ST_OK : ST_NOTFOUND;
                v.body_length = (target_ok != 0) ? page_bytes : NOT_FOUND_LEN;
                v.send_body   = (flags & VF_GET) != 0;
            end
            expected_verdicts.push_back(v);
        endfunction

        function void take_byte(logic [7:0] c, logic lost);
            result_t v;
            if (lost) begin
                v.status      = ST_NOREQ;
                v.send_body   = 1'b0;
                v.body_length = '0;
                expected_verdicts.push_back(v);
                restart();
                return;
            end
            parse(c);
            scan(c);
            held = held + 12'd1;
            if (crlf_seen == SEEN_END || held >= BUF_BYTES - 1) begin
                conclude();
                restart();
            end
        endfunction

        function void check_verdict(logic [2:0] st, logic sb, logic [15:0] len);
            result_t want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict status %0d send_body %0d body_length %0d",
                         $time, st, sb, len);
                mismatches++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (st !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                mismatches++;
            end
            if (sb !== want.send_body) begin
                $display("%0t: send_body expected %0d actual %0d", $time, want.send_body, sb);
                mismatches++;
            end
            if (len !== want.body_length) begin
                $display("%0t: body_length expected %0d actual %0d",
                         $time, want.body_length, len);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = '0;
    logic        s_connection_lost = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_send_body;
    logic [15:0] m_body_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    verdict_predictor board;
    logic             steady_flow = 1'b0;   // no idling on either side while set
    int unsigned      cycle_count = 0;
    int unsigned      beats_sent = 0;
    string            near_miss_methods[6] = '{"GE", "GETT", "HEA", "HEADS", "get", "POST"};

    http_request_classifier_top #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_value     (s_byte_value),
        .s_connection_lost(s_connection_lost),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_send_body      (m_send_body),
        .m_body_length    (m_body_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver stalls at random outside the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // every verdict beat is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_verdict(m_status, m_send_body, m_body_length);
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** http_request_classifier_top: FAILED **");
            $finish;
        end
    end

    // one request byte, with random gaps before it; prediction on acceptance
    task automatic send_beat(input logic [7:0] b, input logic lost);
        while (!steady_flow && $urandom_range(99, 0) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_byte_value      <= b;
        s_connection_lost <= lost;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.take_byte(b, lost);
        beats_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_beat(t[i], 1'b0);
    endtask

    task automatic send_repeat(input logic [7:0] b, input int n);
        repeat (n) send_beat(b, 1'b0);
    endtask

    // client goes away; the byte on the bus is don't-care
    task automatic drop_link();
        send_beat(8'($urandom_range(255, 0)), 1'b1);
    endtask

    // stop sending and wait for every outstanding verdict plus the pipeline depth
    task automatic settle();
        s_valid <= 1'b0;
        while (board.expected_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_page_length(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        board.page_bytes = v;
    endtask

    task automatic send_path_chars(input int n);
        repeat (n) send_beat(8'h21 + 8'($urandom_range(93, 0)), 1'b0);
    endtask

    // mostly well formed requests with random content, some noise and broken ones
    task automatic random_request();
        int kind;
        int pick;
        kind = $urandom_range(99, 0);
        if (kind < 8) begin
            repeat ($urandom_range(30, 1)) send_beat(8'($urandom_range(255, 0)), 1'b0);
            drop_link();
            return;
        end

        // method token
        pick = $urandom_range(9, 0);
        if (pick < 4) send_text("GET");
        else if (pick < 7) send_text("HEAD");
        else if (pick < 9) send_text(near_miss_methods[$urandom_range(5, 0)]);
        else repeat ($urandom_range(6, 1)) send_beat(8'h41 + 8'($urandom_range(25, 0)), 1'b0);

        // separator, now and then broken
        if (kind < 14) begin
            case ($urandom_range(3, 0))
                0: send_beat(CH_NUL, 1'b0);
                1: send_beat(CH_CR, 1'b0);
                2: send_beat(CH_LF, 1'b0);
                default: send_text("  ");
            endcase
        end else begin
            send_beat(CH_SPACE, 1'b0);
        end

        // target token
        case ($urandom_range(9, 0))
            0, 1: send_text("/");
            2, 3: send_text("/index.html");
            4: begin
                send_text("/index.html?");
                send_path_chars($urandom_range(8, 0));
            end
            5: begin
                send_text("/?");
                send_path_chars($urandom_range(8, 0));
            end
            6: send_text("/index.htm");
            7: begin
                if ($urandom_range(19, 0) == 0) send_repeat(8'h7a, 300);
                else send_path_chars($urandom_range(12, 1));
            end
            8: begin
                send_text("/");
                send_path_chars($urandom_range(12, 1));
            end
            default: ;
        endcase

        send_text(" HTTP/1.1\r\n");
        repeat ($urandom_range(2, 0)) begin
            send_text("X-H: ");
            repeat ($urandom_range(6, 0)) send_beat(8'($urandom_range(255, 0)), 1'b0);
            send_text("\r\n");
        end
        if (kind >= 95) drop_link();
        else send_text("\r\n");
    endtask

    initial begin
        int phase_beats;
        int phase_requests;
        logic [15:0] page_choices[3];

        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset value of page_length first
        drop_link();
        send_text("GET / HTTP/1.1\r\n\r\n");
        settle();
        write_page_length(16'hffff);

        send_text("HEAD /index.html HTTP/1.0\r\nHost: a\r\n\r\n");
        send_text("GET /index.html?x=1&y=2 HTTP/1.1\r\n\r\n");
        send_text("GET /?q HTTP/1.1\r\n\r\n");
        send_text("GET /missing HTTP/1.1\r\n\r\n");
        send_text("HEAD /index.htm HTTP/1.1\r\n\r\n");
        send_text("GET ?only HTTP/1.1\r\n\r\n");
        send_text("POST / HTTP/1.1\r\n\r\n");
        send_text("GETS / HTTP/1.1\r\n\r\n");
        send_text("GET\r\n\r\n");
        send_text("GET  / HTTP/1.1\r\n\r\n");
        send_text("\r\n\r\n");
        send_text("GET /\r\n\r\n");

        // nul ends the method, then ends a target
        send_text("GET");
        send_beat(CH_NUL, 1'b0);
        send_text(" / x\r\n\r\n");
        send_text("GET /");
        send_beat(CH_NUL, 1'b0);
        send_text("\r\n\r\n");

        // top byte value inside a target, then a link drop mid request
        send_text("HEAD /");
        send_beat(8'hff, 1'b0);
        send_text(" \r\n\r\n");
        send_text("GET /index");
        drop_link();

        // broken blank line does not end the headers
        send_text("GET / HTTP/1.1\r\n\rX\r\n\r\n");

        // saturating token positions
        send_repeat("G", 300);
        send_text(" / \r\n\r\n");
        send_text("GET /");
        send_repeat("a", 300);
        send_text(" \r\n\r\n");

        // buffer full in the method, in an open target and after the line
        send_repeat("A", BUF_BYTES - 1);
        send_text("GET /");
        send_repeat("b", BUF_BYTES - 6);
        send_text("GET / HTTP/1.1\r\n");
        send_repeat("x", BUF_BYTES - 17);

        // random traffic in three settings, the middle one without any idling
        page_choices[0] = 16'h0000;
        page_choices[1] = 16'($urandom_range(65535, 0));
        page_choices[2] = 16'd1;
        for (int p = 0; p < 3; p++) begin
            settle();
            write_page_length(page_choices[p]);
            steady_flow = (p == 1);
            phase_beats    = 0;
            phase_requests = 0;
            while (phase_beats < 440 || phase_requests < 20) begin
                int start_beats;
                start_beats = beats_sent;
                random_request();
                phase_beats += beats_sent - start_beats;
                phase_requests++;
            end
            drop_link();
            steady_flow = 1'b0;
        end

        settle();
        if (board.mismatches == 0)
            $display("** http_request_classifier_top: PASSED **");
        else
            $display("** http_request_classifier_top: FAILED **");
        $finish;
    end

endmodule
